FILE: sv/diffusion_stencil_step_2d_core_defines.svh
// ----------------------------------------------------------------------------
// Diffusion stencil assertion macros
// Shared property forms for the checker; all are clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_STENCIL_STEP_2D_CORE_DEFINES_SVH
`define DIFFUSION_STENCIL_STEP_2D_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent match.
`define DSS2D_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dss2d: property violated");

// Consequent checked in the cycle after the antecedent match.
`define DSS2D_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dss2d: property violated");

`endif

FILE: sv/dss2d_pkg.sv
// ----------------------------------------------------------------------------
// Diffusion stencil package
// Widths, register map and small helpers shared by the core and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dss2d_pkg;

  localparam int MaxCols    = 1024;
  localparam int MaxRows    = 1024;
  localparam int SampleBits = 32;
  localparam int CoeffBits  = 16;
  localparam int DimBits    = 11;
  localparam int ColBits    = $clog2(MaxCols);
  localparam int RowBits    = $clog2(MaxRows + 1);
  localparam int MinDim     = 3;

  localparam int PairBits   = SampleBits + 1;
  localparam int LapBits    = SampleBits + 3;
  localparam int ProdBits   = LapBits + CoeffBits + 1;
  localparam int ScaledBits = ProdBits - CoeffBits;
  localparam int SumBits    = ScaledBits + 1;

  localparam int DataBits   = 32;
  localparam int AddrBits   = 4;
  localparam int RegIdxBits = 2;

  typedef enum logic [RegIdxBits-1:0] {
    REG_STEP_COEFF = 2'd0,
    REG_GRID_ROWS  = 2'd1,
    REG_GRID_COLS  = 2'd2
  } dss2d_reg_e;

  // Effective grid size: written value held to [MinDim, hi].
  function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v,
                                                   input logic [DimBits-1:0] hi);
    logic [DimBits-1:0] r;
    if (v < DimBits'(MinDim)) begin
      r = DimBits'(MinDim);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/diffusion_stencil_step_2d_core.sv
// ----------------------------------------------------------------------------
// Diffusion stencil step core
// Five-point explicit diffusion update over a raster-ordered grid stream.
// ----------------------------------------------------------------------------
// The core takes one sample per clock unless a held result backs up the whole
// pipeline; each result passes stages s1, s2, s3 and the output register after
// the transfer of the sample directly below its cell, so results run one grid
// row behind the input. The first row of a grid gives no results, and one extra
// row of grid_cols padding transfers after the grid flushes the last row (the
// last result carries grid_done).
// Two 1024 x 32 line stores, each with one write and one registered read per
// cycle, hold the two previous rows; their reads are issued one and two
// columns ahead, so no clearing pass is needed after reset. The four stages
// are operand sums, the Laplacian, the coefficient multiply and the
// saturating add. Writing grid_rows or grid_cols restarts the grid.
`timescale 1ns / 1ps

module diffusion_stencil_step_2d_core import dss2d_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Sample input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SampleBits-1:0] sample_value_i,
  // Result output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SampleBits-1:0] new_value_o,
  output logic                         grid_done_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AddrBits-1:0]          paddr,
  input  logic [DataBits-1:0]          pwdata,
  output logic [DataBits-1:0]          prdata,
  output logic                         pready
);

  // Configuration registers
  logic [CoeffBits-1:0] coeff_q;
  logic [DimBits-1:0]   rows_q;
  logic [DimBits-1:0]   cols_q;
  logic                 cfg_wr;
  logic                 cfg_restart;
  dss2d_reg_e           reg_idx;

  // Grid position and line store access
  logic [RowBits-1:0]   row_q, row_d;
  logic [ColBits-1:0]   col_q, col_d;
  logic [DimBits-1:0]   nr, nc, nc_m1, col_ext;
  logic                 col_last, padding, has_res, ring, done;
  logic [ColBits-1:0]   rec_raddr, old_raddr;
  logic                 in_acc;

  logic signed [SampleBits-1:0] rec_mem [MaxCols];
  logic signed [SampleBits-1:0] old_mem [MaxCols];
  logic signed [SampleBits-1:0] rec_rd_q, old_rd_q, cen_q, lft_q;

  // Pipeline stages
  logic                         s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                         s1_ok, s2_ok, s3_ok, out_ok;
  logic signed [PairBits-1:0]   s1_ns_q, s1_ew_q;
  logic signed [SampleBits-1:0] s1_cen_q, s2_cen_q, s3_cen_q;
  logic                         s1_ring_q, s2_ring_q, s3_ring_q;
  logic                         s1_done_q, s2_done_q, s3_done_q;
  logic signed [LapBits-1:0]    lap_d, s2_lap_q;
  logic signed [ProdBits-1:0]   prod;
  logic signed [ScaledBits-1:0] s3_scaled_q;
  logic signed [SumBits-1:0]    sum;
  logic signed [SampleBits-1:0] res_d, res_q;
  logic                         done_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready      = 1'b1;
  assign reg_idx     = dss2d_reg_e'(paddr[AddrBits-1:AddrBits-RegIdxBits]);
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_restart = cfg_wr & ((reg_idx == REG_GRID_ROWS) | (reg_idx == REG_GRID_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
      rows_q  <= DimBits'(MaxRows);
      cols_q  <= DimBits'(MaxCols);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STEP_COEFF: coeff_q <= pwdata[CoeffBits-1:0];
        REG_GRID_ROWS:  rows_q  <= pwdata[DimBits-1:0];
        REG_GRID_COLS:  cols_q  <= pwdata[DimBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP_COEFF: prdata = DataBits'(coeff_q);
      REG_GRID_ROWS:  prdata = DataBits'(rows_q);
      REG_GRID_COLS:  prdata = DataBits'(cols_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Position tracking
  // --------------------------------------------------------------------------
  assign nr       = clamp_dim(rows_q, DimBits'(MaxRows));
  assign nc       = clamp_dim(cols_q, DimBits'(MaxCols));
  assign nc_m1    = nc - DimBits'(1);
  assign col_ext  = DimBits'(col_q);
  assign col_last = (col_ext == nc_m1);
  // The padding row is also the row whose transfers finish the last grid row.
  assign padding  = (DimBits'(row_q) == nr);
  assign has_res  = (row_q != '0);
  assign ring     = (row_q == RowBits'(1)) | padding | (col_q == '0) | col_last;
  assign done     = padding & col_last;

  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_restart) begin
      row_d = '0;
      col_d = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_d = '0;
        row_d = padding ? '0 : row_q + RowBits'(1);
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      lft_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (cfg_restart) begin
        lft_q <= '0;
      end else if (in_acc) begin
        lft_q <= cen_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line stores
  // --------------------------------------------------------------------------
  // The recent store is read two columns ahead and the older one a column
  // ahead, wrapping into the next row; neither ever hits the write address.
  always_comb begin
    if (col_last) begin
      rec_raddr = ColBits'(1);
    end else if (col_ext == nc_m1 - DimBits'(1)) begin
      rec_raddr = '0;
    end else begin
      rec_raddr = col_q + ColBits'(2);
    end
    old_raddr = col_last ? '0 : col_q + ColBits'(1);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!padding) begin
        rec_mem[col_q] <= sample_value_i;
        old_mem[col_q] <= cen_q;
      end
      rec_rd_q <= rec_mem[rec_raddr];
      old_rd_q <= old_mem[old_raddr];
      cen_q    <= rec_rd_q;
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic pipeline
  // --------------------------------------------------------------------------
  assign out_ok     = ~out_v_q | ~out_stall_i;
  assign s3_ok      = ~s3_v_q | out_ok;
  assign s2_ok      = ~s2_v_q | s3_ok;
  assign s1_ok      = ~s1_v_q | s2_ok;
  assign in_stall_o = ~s1_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ok) begin
        s1_v_q <= in_acc & has_res;
      end
      if (s2_ok) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ok) begin
        s3_v_q <= s2_v_q;
      end
      if (out_ok) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  // Laplacian: north + south + east + west - 4 * center.
  assign lap_d = LapBits'(s1_ns_q) + LapBits'(s1_ew_q)
               - {s1_cen_q[SampleBits-1], s1_cen_q, 2'b00};

  assign prod = s2_lap_q * $signed({1'b0, coeff_q});

  assign sum = SumBits'(s3_cen_q) + SumBits'(s3_scaled_q);

  // Saturate when the bits above the sample width disagree with its sign.
  always_comb begin
    if (s3_ring_q) begin
      res_d = s3_cen_q;
    end else if (sum[SumBits-1:SampleBits-1] == '0 || sum[SumBits-1:SampleBits-1] == '1) begin
      res_d = sum[SampleBits-1:0];
    end else if (sum[SumBits-1]) begin
      res_d = {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(SampleBits-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ok) begin
      s1_ns_q   <= PairBits'(old_rd_q) + PairBits'(sample_value_i);
      s1_ew_q   <= PairBits'(rec_rd_q) + PairBits'(lft_q);
      s1_cen_q  <= cen_q;
      s1_ring_q <= ring;
      s1_done_q <= done;
    end
    if (s2_ok) begin
      s2_lap_q  <= lap_d;
      s2_cen_q  <= s1_cen_q;
      s2_ring_q <= s1_ring_q;
      s2_done_q <= s1_done_q;
    end
    if (s3_ok) begin
      // Dropping the fraction bits floors the product.
      s3_scaled_q <= prod[ProdBits-1:CoeffBits];
      s3_cen_q    <= s2_cen_q;
      s3_ring_q   <= s2_ring_q;
      s3_done_q   <= s2_done_q;
    end
    if (out_ok) begin
      res_q  <= res_d;
      done_q <= s3_done_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign new_value_o = res_q;
  assign grid_done_o = done_q;

endmodule

FILE: sv/dss2d_checker.sv
// ----------------------------------------------------------------------------
// Diffusion stencil checker
// Port-level properties of the stencil core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "diffusion_stencil_step_2d_core_defines.svh"

module dss2d_checker import dss2d_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [SampleBits-1:0] new_value_o,
  input logic                         grid_done_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [AddrBits-1:0]          paddr,
  input logic [DataBits-1:0]          pwdata,
  input logic [DataBits-1:0]          prdata,
  input logic                         pready
);

  logic cols_wr, cols_rd;

  assign cols_wr = psel & penable & pwrite & pready &
                   (paddr[AddrBits-1:AddrBits-RegIdxBits] == REG_GRID_COLS);
  assign cols_rd = psel & ~pwrite &
                   (paddr[AddrBits-1:AddrBits-RegIdxBits] == REG_GRID_COLS);

  // A result that is held back keeps its value until the transfer.
  `DSS2D_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(new_value_o) && $stable(grid_done_o))

  // The input is only held off when the whole pipeline is backed up.
  `DSS2D_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // The column count reads back as written on the next cycle.
  `DSS2D_ASSERT_IMP(a_cols_readback, cols_wr ##1 cols_rd, prdata[DimBits-1:0] == $past(pwdata[DimBits-1:0]))

  // A configuration access always completes without wait states.
  `DSS2D_ASSERT_IMP(a_no_wait, psel && penable, pready)

endmodule

bind diffusion_stencil_step_2d_core dss2d_checker u_dss2d_checker (.*);
